### sv/aes_rr_pkg.sv
// Package for the reduced-round AES-128 encryption unit.
// Holds the S-box, GF(2^8) helpers, round-function helpers and constants.
// No dependencies.
package aes_rr_pkg;

   localparam int unsigned DefaultRoundCount = 1;
   localparam int unsigned HalfWidth = 64;
   localparam int unsigned CsrIndexWidth = 1;

   typedef logic [127:0] block_type;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_KEY_HIGH = 1'b0,
      CSR_KEY_LOW  = 1'b1
   } csr_index_type;

   // One pipeline cell's payload: state, round key and round constant.
   typedef struct packed {
      block_type   state;
      block_type   round_key;
      logic [7:0]  rcon;
   } cell_data_type;

   localparam logic [7:0] SBOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   // Byte k of a block; byte 0 is the most significant.
   function automatic logic [7:0] get_byte(input block_type b, input int unsigned k);
      return b[127 - 8*k -: 8];
   endfunction

   function automatic logic [7:0] gf_double(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   // Next AES-128 round key.
   function automatic block_type expand_next(input block_type rk, input logic [7:0] rcon);
      logic [7:0] t [4];
      logic [7:0] b;
      block_type  nk;
      nk = rk;
      t[0] = SBOX[get_byte(rk, 13)] ^ rcon;
      t[1] = SBOX[get_byte(rk, 14)];
      t[2] = SBOX[get_byte(rk, 15)];
      t[3] = SBOX[get_byte(rk, 12)];
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            b = get_byte(rk, 4*c + r) ^ t[r];
            nk[127 - 8*(4*c + r) -: 8] = b;
            t[r] = b;
         end
      end
      return nk;
   endfunction

   // SubBytes, ShiftRows, MixColumns and AddRoundKey.
   function automatic block_type one_round(input block_type s, input block_type rk);
      logic [7:0] u [16];
      logic [7:0] a0, a1, a2, a3;
      block_type  o;
      o = '0;
      for (int c = 0; c < 4; c++)
         for (int r = 0; r < 4; r++)
            u[4*c + r] = SBOX[get_byte(s, 4*((c + r) % 4) + r)];
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            a0 = u[4*c + r];
            a1 = u[4*c + (r + 1) % 4];
            a2 = u[4*c + (r + 2) % 4];
            a3 = u[4*c + (r + 3) % 4];
            o[127 - 8*(4*c + r) -: 8] = gf_double(a0) ^ gf_double(a1) ^ a1 ^ a2 ^ a3
                                        ^ get_byte(rk, 4*c + r);
         end
      end
      return o;
   endfunction

endpackage

### sv/aes_rr_if.sv
// Channel interfaces for the reduced-round AES-128 encryption unit.
// Depends on aes_rr_pkg for the register index and data widths.
interface aes_rr_block_if;
   logic        valid;
   logic        ready;
   logic [63:0] high;
   logic [63:0] low;
   modport source (output valid, high, low, input ready);
   modport sink (input valid, high, low, output ready);
endinterface

interface aes_rr_csr_if import aes_rr_pkg::*; ;
   logic                      valid;
   logic                      ready;
   logic [CsrIndexWidth-1:0]  index;
   logic [HalfWidth-1:0]      data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

### sv/aes128_reduced_round_encrypt_unit.sv
// Top level of the reduced-round AES-128 encryption unit.
// Depends on aes_rr_pkg, aes_rr_if and aes_rr_cell.
//
// Usage: the cipher key is written over the csr_ channel (index CSR_KEY_HIGH
// for key bytes 0..7, CSR_KEY_LOW for bytes 8..15) while the unit is idle.
// Plaintext blocks arrive as req_ transfers of two 64-bit halves, and each
// one yields exactly one rsp_ transfer carrying the ciphertext halves.
// The datapath is a row of ROUND_COUNT identical round cells behind an input
// stage that applies the initial AddRoundKey. Each cell registers its result
// and hands it to its neighbor every cycle in which the row advances,
// expanding its own round key on the way. A new block is taken every
// cycle while the row advances: throughput is one block per cycle, set
// by the single round function in each cell.
// The whole row advances together when the last cell is empty or the
// receiver takes its result; a stalled receiver freezes the row, and the
// request side stalls in every cycle in which a finished result waits for
// the receiver, whether or not the earlier stages hold blocks.
// A synchronous reset empties every stage and clears the key to zero.
module aes128_reduced_round_encrypt_unit import aes_rr_pkg::*; #(
   parameter int unsigned ROUND_COUNT = DefaultRoundCount
) (
   input  logic clock,
   input  logic reset,
   aes_rr_block_if.sink   req_block,
   aes_rr_block_if.source rsp_cipher,
   aes_rr_csr_if.sink     csr
);
   logic [HalfWidth-1:0] key_high_ff, key_low_ff;
   logic                 advance;
   logic                 in_valid_ff;
   cell_data_type        in_data_ff;
   logic                 valid_chain [ROUND_COUNT+1];
   cell_data_type        data_chain  [ROUND_COUNT+1];

   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= '0;
         key_low_ff <= '0;
      end else if (csr.valid) begin
         case (csr.index)
            CSR_KEY_HIGH: key_high_ff <= csr.data;
            CSR_KEY_LOW:  key_low_ff <= csr.data;
            default: ;
         endcase
      end
   end

   // The row moves when the output slot is free or being drained.
   assign advance = !valid_chain[ROUND_COUNT] || rsp_cipher.ready;
   assign req_block.ready = advance;

   // Input stage: initial AddRoundKey.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (advance) begin
         in_valid_ff <= req_block.valid;
      end
      if (advance) begin
         in_data_ff.state <= {req_block.high, req_block.low} ^ {key_high_ff, key_low_ff};
         in_data_ff.round_key <= {key_high_ff, key_low_ff};
         in_data_ff.rcon <= 8'h01;
      end
   end

   assign valid_chain[0] = in_valid_ff;
   assign data_chain[0] = in_data_ff;

   for (genvar i = 0; i < ROUND_COUNT; i++) begin : g_cell
      aes_rr_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .valid_in  (valid_chain[i]),
         .data_in   (data_chain[i]),
         .valid_out (valid_chain[i+1]),
         .data_out  (data_chain[i+1])
      );
   end

   assign rsp_cipher.valid = valid_chain[ROUND_COUNT];
   assign rsp_cipher.high = data_chain[ROUND_COUNT].state[127:64];
   assign rsp_cipher.low = data_chain[ROUND_COUNT].state[63:0];

`ifndef ASSERT_OFF
   // A stalled result must stay put until the receiver takes it.
   a_hold_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_cipher.valid && !rsp_cipher.ready |=> rsp_cipher.valid && $stable(rsp_cipher.high))
      else $error("result changed under stall");
   // The request side is refused only while the result is stalled.
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !req_block.ready |-> rsp_cipher.valid && !rsp_cipher.ready)
      else $error("request refused without stall");
   // After reset the pipe is empty.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_cipher.valid)
      else $error("result valid after reset");
`endif
endmodule

### sv/aes_rr_cell.sv
// One round cell of the encryption pipeline: key expansion and round function.
// Depends on aes_rr_pkg.
module aes_rr_cell import aes_rr_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          advance,
   input  logic          valid_in,
   input  cell_data_type data_in,
   output logic          valid_out,
   output cell_data_type data_out
);
   logic          valid_ff, valid_in_c;
   cell_data_type data_ff, data_in_c;
   block_type     next_key;

   always_comb begin
      next_key = expand_next(data_in.round_key, data_in.rcon);
      data_in_c.round_key = next_key;
      data_in_c.state = one_round(data_in.state, next_key);
      data_in_c.rcon = gf_double(data_in.rcon);
      valid_in_c = valid_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in_c;
      end
      if (advance) begin
         data_ff <= data_in_c;
      end
   end

   assign valid_out = valid_ff;
   assign data_out = data_ff;
endmodule

### tb/aes128_reduced_round_encrypt_unit_tb.sv
// Self-checking testbench for the reduced-round AES-128 encryption unit.
// Depends on aes_rr_pkg for types and register indexes, and on aes_rr_if for the channels.
// It checks every ciphertext against its own round-by-round cipher calculation.
`timescale 1ns / 100ps

module aes128_reduced_round_encrypt_unit_tb;
   import aes_rr_pkg::*;

   localparam int unsigned Rounds = DefaultRoundCount;
   localparam int unsigned CycleLimit = 400000;

   typedef logic [7:0] byte_array_type [16];

   // Keeps the current key, works out the ciphertext of each accepted block and
   // compares each response against the oldest ciphertext that is still waiting.
   class cipher_scoreboard;
      logic [127:0] key;
      logic [127:0] pending_cipher [$];
      int           errors;

      function new();
         key = '0;
         errors = 0;
      endfunction

      static function logic [7:0] xtime(logic [7:0] a);
         return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
      endfunction

      function logic [127:0] encrypt(logic [127:0] plain);
         byte_array_type st, rk, sh;
         logic [7:0]     t [4];
         logic [7:0]     rc;
         logic [127:0]   out;
         for (int k = 0; k < 16; k++) begin
            st[k] = plain[127 - 8*k -: 8];
            rk[k] = key[127 - 8*k -: 8];
            st[k] ^= rk[k];
         end
         rc = 8'h01;
         for (int n = 0; n < Rounds; n++) begin
            // Next round key from the AES-128 schedule.
            t[0] = SBOX[rk[13]] ^ rc;
            t[1] = SBOX[rk[14]];
            t[2] = SBOX[rk[15]];
            t[3] = SBOX[rk[12]];
            for (int c = 0; c < 4; c++)
               for (int r = 0; r < 4; r++) begin
                  rk[4*c + r] ^= t[r];
                  t[r] = rk[4*c + r];
               end
            // SubBytes with ShiftRows, then MixColumns and AddRoundKey.
            for (int c = 0; c < 4; c++)
               for (int r = 0; r < 4; r++)
                  sh[4*c + r] = SBOX[st[4*((c + r) % 4) + r]];
            for (int c = 0; c < 4; c++)
               for (int r = 0; r < 4; r++)
                  st[4*c + r] = xtime(sh[4*c + r]) ^ xtime(sh[4*c + (r+1)%4])
                     ^ sh[4*c + (r+1)%4] ^ sh[4*c + (r+2)%4] ^ sh[4*c + (r+3)%4]
                     ^ rk[4*c + r];
            rc = xtime(rc);
         end
         for (int k = 0; k < 16; k++) out[127 - 8*k -: 8] = st[k];
         return out;
      endfunction

      function void set_key(csr_index_type idx, logic [63:0] value);
         if (idx == CSR_KEY_HIGH) key[127:64] = value;
         else key[63:0] = value;
      endfunction

      function void note_block(logic [63:0] high, logic [63:0] low);
         pending_cipher.push_back(encrypt({high, low}));
      endfunction

      function void check_cipher(logic [63:0] high, logic [63:0] low);
         logic [127:0] want;
         if (pending_cipher.size() == 0) begin
            $display("%0t: unexpected response %h_%h", $time, high, low);
            errors++;
            return;
         end
         want = pending_cipher.pop_front();
         if (high !== want[127:64]) begin
            $display("%0t: cipher_high expected %h actual %h", $time, want[127:64], high);
            errors++;
         end
         if (low !== want[63:0]) begin
            $display("%0t: cipher_low expected %h actual %h", $time, want[63:0], low);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   cycle_count = 0;
   // The receiver's idling is turned off for the last part of the run.
   bit   quiet_tail = 1'b0;
   // Set while the receiver holds off on purpose to fill the pipeline.
   bit   long_hold = 1'b0;

   cipher_scoreboard board = new();

   aes_rr_block_if req_if ();
   aes_rr_block_if rsp_if ();
   aes_rr_csr_if   csr_if ();

   aes128_reduced_round_encrypt_unit #(.ROUND_COUNT(Rounds)) dut (
      .clock(clock),
      .reset(reset),
      .req_block(req_if.sink),
      .rsp_cipher(rsp_if.source),
      .csr(csr_if.sink)
   );

   always #5 clock = ~clock;

   // Every input is driven to a known value from time zero.
   initial begin
      req_if.valid = 1'b0;
      req_if.high = '0;
      req_if.low = '0;
      csr_if.valid = 1'b0;
      csr_if.index = CSR_KEY_HIGH;
      csr_if.data = '0;
      rsp_if.ready = 1'b0;
   end

   // Watchdog. A hang prints the failure and ends the run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Both channels are sampled at the rising edge. A transfer takes place when
   // valid and ready are high together at that edge.
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready)
         board.check_cipher(rsp_if.high, rsp_if.low);
      if (!reset && req_if.valid && req_if.ready)
         board.note_block(req_if.high, req_if.low);
   end

   // The receiver changes ready at the falling edge. It stalls in random bursts,
   // and once it holds off for a long stretch so that the row fills and
   // stops taking requests.
   initial begin
      int gap;
      @(negedge clock);
      while (1) begin
         if (long_hold) begin
            rsp_if.ready <= 1'b0;
            repeat (60) @(negedge clock);
            long_hold = 1'b0;
         end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 11);
            rsp_if.ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end else begin
            rsp_if.ready <= 1'b1;
            @(negedge clock);
         end
      end
   end

   // Writes one key register and waits until the write is taken.
   task automatic write_key(csr_index_type idx, logic [63:0] value);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data <= value;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      board.set_key(idx, value);
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   // Offers one block and waits for the transfer. A random idle gap may come
   // before it unless idling is turned off.
   task automatic send_block(logic [63:0] high, logic [63:0] low, bit may_idle);
      if (may_idle && $urandom_range(0, 5) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(negedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.high <= high;
      req_if.low <= low;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      @(negedge clock);
   endtask

   // Lowers valid once the last block of a phase has gone across.
   task automatic end_burst();
      req_if.valid <= 1'b0;
   endtask

   // Waits until every ciphertext has come back, then lets the row settle.
   task automatic drain();
      while (board.pending_cipher.size() != 0) @(negedge clock);
      repeat (Rounds + 4) @(negedge clock);
   endtask

   // Random half block with a random byte pattern: full random, all zero or all ones.
   function automatic logic [63:0] random_half();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         default: return {$urandom(), $urandom()};
      endcase
   endfunction

   initial begin
      logic [63:0] key_values [4];
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part with the key at its reset value of zero, so the
      // all-zero key and the block extremes are covered first.
      send_block('0, '0, 1'b0);
      send_block('1, '1, 1'b0);
      send_block(64'h0011223344556677, 64'h8899aabbccddeeff, 1'b0);
      send_block(64'h8000000000000000, 64'h0000000000000001, 1'b0);
      end_burst();
      drain();

      // Four key values, each written to the high half with its complement in the low half.
      key_values[0] = '1;
      key_values[1] = 64'h2b7e151628aed2a6;
      key_values[2] = 64'h8080808080808080;
      key_values[3] = 64'h0101010101010101;
      for (int k = 0; k < 4; k++) begin
         write_key(CSR_KEY_HIGH, key_values[k]);
         write_key(CSR_KEY_LOW, ~key_values[k]);
         send_block('0, '0, 1'b0);
         send_block('1, '1, 1'b0);
         send_block(64'h3243f6a8885a308d, 64'h313198a2e0370734, 1'b0);
         send_block(64'haaaaaaaaaaaaaaaa, 64'h5555555555555555, 1'b0);
         end_burst();
         drain();
      end

      // Pipeline fill: the receiver holds off while blocks keep coming.
      long_hold = 1'b1;
      for (int n = 0; n < 20; n++) send_block(random_half(), random_half(), 1'b0);
      end_burst();
      drain();

      // Random phases, each under a fresh random key.
      for (int phase = 0; phase < 6; phase++) begin
         write_key(CSR_KEY_HIGH, random_half());
         write_key(CSR_KEY_LOW, random_half());
         if (phase == 5) quiet_tail = 1'b1;
         for (int n = 0; n < 95; n++)
            send_block(random_half(), random_half(), !quiet_tail);
         end_burst();
         drain();
      end

      if (board.errors == 0 && board.pending_cipher.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
